@@ hdl/assert_macros.svh @@
// assertion helpers used by the rtl sequencer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked at every clock edge outside reset
`define RLBP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("rlbp check failed");

// implication checked at every clock edge outside reset
`define RLBP_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlbp check failed");

`endif

@@ hdl/rlbp_pkg.sv @@
`timescale 1ns / 1ps
package rlbp_pkg;

   localparam int ENTRIES_DEF      = 32;
   localparam int OWNER_BITS_DEF   = 16;
   localparam int REQUEST_BITS_DEF = 32;

   localparam int OP_W      = 3;
   localparam int OWNER_W   = 16;
   localparam int REQUEST_W = 32;
   localparam int SIZE_W    = 32;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 5;
   localparam int REF_W     = 16;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [REF_W-1:0] REFS_MAX = '1;

   localparam logic [OP_W-1:0] OP_STORE   = 3'd0;
   localparam logic [OP_W-1:0] OP_ACQUIRE = 3'd1;
   localparam logic [OP_W-1:0] OP_GET     = 3'd2;
   localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ABSENT = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUP    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MEM    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTACT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;
   localparam logic [STATUS_W-1:0] ST_EVICT  = 3'd6;

   localparam logic CSR_LIMIT = 1'b0;

   typedef logic [STATUS_W-1:0] status_type;

endpackage

@@ hdl/rlbp_if.sv @@
`timescale 1ns / 1ps
interface rlbp_req_if;
   import rlbp_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [OWNER_W-1:0]   owner_id;
   logic [REQUEST_W-1:0] request_key;
   logic [SIZE_W-1:0]    item_size_kb;
   modport source (output valid, op, owner_id, request_key, item_size_kb, input ready);
   modport sink (input valid, op, owner_id, request_key, item_size_kb, output ready);
endinterface

interface rlbp_rsp_if;
   import rlbp_pkg::*;
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [SLOT_W-1:0]    slot;
   logic [OWNER_W-1:0]   evicted_owner;
   logic [REQUEST_W-1:0] evicted_request;
   logic [REF_W-1:0]     ref_count;
   logic [SIZE_W-1:0]    usage_kb;
   logic                 last;
   modport source (output valid, status, slot, evicted_owner, evicted_request, ref_count,
                   usage_kb, last, input ready);
   modport sink (input valid, status, slot, evicted_owner, evicted_request, ref_count,
                 usage_kb, last, output ready);
endinterface

@@ hdl/rlbp_ram.sv @@
`timescale 1ns / 1ps
module rlbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ hdl/rlbp_csr.sv @@
`timescale 1ns / 1ps
module rlbp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rlbp_pkg::CSR_AW-1:0] paddr,
   input  logic [rlbp_pkg::CSR_DW-1:0] pwdata,
   output logic [rlbp_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output logic [rlbp_pkg::SIZE_W-1:0] limit_kb
);
   import rlbp_pkg::*;

   logic [SIZE_W-1:0] limit_ff, limit_in;
   logic              wr_en;

   assign wr_en = psel && penable && pwrite;

   always_comb begin
      limit_in = limit_ff;
      if (wr_en && paddr[2] == CSR_LIMIT) begin
         limit_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata   = (paddr[2] == CSR_LIMIT) ? limit_ff : '0;
   assign pready   = 1'b1;
   assign limit_kb = limit_ff;
endmodule

@@ hdl/rlbp_seq.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rlbp_seq #(
   parameter int ENTRIES      = rlbp_pkg::ENTRIES_DEF,
   parameter int OWNER_BITS   = rlbp_pkg::OWNER_BITS_DEF,
   parameter int REQUEST_BITS = rlbp_pkg::REQUEST_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   rlbp_req_if.sink                    req_if,
   rlbp_rsp_if.source                  rsp_if,
   input  logic [rlbp_pkg::SIZE_W-1:0] limit_kb
);
   import rlbp_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int DW = OWNER_BITS + REQUEST_BITS + REF_W + SIZE_W;
   localparam logic [CW-1:0] LAST_IDX = CW'(ENTRIES - 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_LK_RD   = 4'd1;
   localparam logic [3:0] S_LK_CMP  = 4'd2;
   localparam logic [3:0] S_DISP    = 4'd3;
   localparam logic [3:0] S_EVAL    = 4'd4;
   localparam logic [3:0] S_ALLOC   = 4'd5;
   localparam logic [3:0] S_FILL    = 4'd6;
   localparam logic [3:0] S_CLR     = 4'd7;
   localparam logic [3:0] S_HD_SCAN = 4'd8;
   localparam logic [3:0] S_HD_DATA = 4'd9;
   localparam logic [3:0] S_RESP    = 4'd10;

   localparam logic [1:0] RET_EVAL = 2'd0;
   localparam logic [1:0] RET_FILL = 2'd1;
   localparam logic [1:0] RET_CLR  = 2'd2;

   logic [3:0]              state_ff, state_in;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [OWNER_BITS-1:0]   own_ff, own_in;
   logic [REQUEST_BITS-1:0] rq_ff, rq_in;
   logic [SIZE_W-1:0]       size_ff, size_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic                    found_ff, found_in;
   logic [IW-1:0]           slot_ff, slot_in;
   logic [REF_W-1:0]        refs_ff, refs_in;
   logic [SIZE_W-1:0]       esz_ff, esz_in;
   logic [1:0]              ret_ff, ret_in;
   logic [ENTRIES-1:0]      val_ff, val_in;
   logic [ENTRIES-1:0]      act_ff, act_in;
   logic [CW-1:0]           rank_ff [ENTRIES];
   logic [CW-1:0]           rank_in [ENTRIES];
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [SIZE_W-1:0]       used_ff, used_in;
   status_type              pst_ff, pst_in;
   logic [IW-1:0]           pslot_ff, pslot_in;
   logic [REF_W-1:0]        prefs_ff, prefs_in;

   logic                    rv_ff, rv_in;
   status_type              r_status_ff, r_status_in;
   logic [SLOT_W-1:0]       r_slot_ff, r_slot_in;
   logic [OWNER_W-1:0]      r_eo_ff, r_eo_in;
   logic [REQUEST_W-1:0]    r_er_ff, r_er_in;
   logic [REF_W-1:0]        r_refs_ff, r_refs_in;
   logic [SIZE_W-1:0]       r_use_ff, r_use_in;
   logic                    r_last_ff, r_last_in;

   logic                    ram_we;
   logic [IW-1:0]           ram_wa;
   logic [DW-1:0]           ram_wd;
   logic [DW-1:0]           ram_rd;
   logic [OWNER_BITS-1:0]   rd_own;
   logic [REQUEST_BITS-1:0] rd_rq;
   logic [REF_W-1:0]        rd_refs;
   logic [SIZE_W-1:0]       rd_size;

   logic                    out_free;
   logic                    remove_en;
   logic [CW-1:0]           remove_r;
   logic                    push_en;
   logic [ENTRIES-1:0]      head_vec;
   logic [REF_W-1:0]        nr;
   logic                    over;
   logic [SIZE_W-1:0]       used_ev;
   logic [IW-1:0]           cur;

   rlbp_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_wa),
      .wdata (ram_wd),
      .raddr (idx_ff[IW-1:0]),
      .rdata (ram_rd)
   );

   assign rd_own  = ram_rd[DW-1 -: OWNER_BITS];
   assign rd_rq   = ram_rd[REF_W+SIZE_W +: REQUEST_BITS];
   assign rd_refs = ram_rd[SIZE_W +: REF_W];
   assign rd_size = ram_rd[SIZE_W-1:0];

   assign out_free = !rv_ff || rsp_if.ready;
   assign cur      = idx_ff[IW-1:0];
   assign over     = ({1'b0, used_ff} + {1'b0, size_ff}) >= {1'b0, limit_kb};
   assign used_ev  = (used_ff >= rd_size) ? (used_ff - rd_size) : '0;

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         head_vec[i] = val_ff[i] && !act_ff[i] && (rank_ff[i] == '0);
      end
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      own_in   = own_ff;
      rq_in    = rq_ff;
      size_in  = size_ff;
      idx_in   = idx_ff;
      found_in = found_ff;
      slot_in  = slot_ff;
      refs_in  = refs_ff;
      esz_in   = esz_ff;
      ret_in   = ret_ff;
      val_in   = val_ff;
      act_in   = act_ff;
      used_in  = used_ff;
      pst_in   = pst_ff;
      pslot_in = pslot_ff;
      prefs_in = prefs_ff;
      ram_we   = 1'b0;
      ram_wa   = slot_ff;
      ram_wd   = {own_ff, rq_ff, refs_ff, esz_ff};
      remove_en = 1'b0;
      remove_r  = rank_ff[slot_ff];
      push_en   = 1'b0;
      nr        = refs_ff;
      rv_in       = rv_ff && !rsp_if.ready;
      r_status_in = r_status_ff;
      r_slot_in   = r_slot_ff;
      r_eo_in     = r_eo_ff;
      r_er_in     = r_er_ff;
      r_refs_in   = r_refs_ff;
      r_use_in    = r_use_ff;
      r_last_in   = r_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_if.valid) begin
               op_in    = req_if.op;
               own_in   = OWNER_BITS'(32'(req_if.owner_id));
               rq_in    = REQUEST_BITS'(48'(req_if.request_key));
               size_in  = req_if.item_size_kb;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = S_LK_RD;
            end
         end
         S_LK_RD: begin
            state_in = S_LK_CMP;
         end
         S_LK_CMP: begin
            if (val_ff[cur] && rd_own == own_ff && rd_rq == rq_ff) begin
               found_in = 1'b1;
               slot_in  = cur;
               refs_in  = rd_refs;
               esz_in   = rd_size;
               state_in = S_DISP;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_DISP;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_LK_RD;
            end
         end
         S_DISP: begin
            state_in = S_RESP;
            pslot_in = slot_ff;
            unique case (op_ff) inside
               OP_STORE, OP_ACQUIRE: begin
                  if (!found_ff) begin
                     if (op_ff == OP_STORE) begin
                        state_in = S_EVAL;
                     end else begin
                        pst_in   = ST_ABSENT;
                        pslot_in = '0;
                        prefs_in = '0;
                     end
                  end else begin
                     if (act_ff[slot_ff]) begin
                        nr = (refs_ff == REFS_MAX) ? refs_ff : refs_ff + REF_W'(1);
                     end else begin
                        nr = REF_W'(1);
                        remove_en = 1'b1;
                        act_in[slot_ff] = 1'b1;
                     end
                     refs_in  = nr;
                     ram_we   = 1'b1;
                     ram_wd   = {own_ff, rq_ff, nr, esz_ff};
                     pst_in   = (op_ff == OP_STORE) ? ST_DUP : ST_OK;
                     prefs_in = nr;
                  end
               end
               OP_GET: begin
                  if (!found_ff) begin
                     pst_in   = ST_ABSENT;
                     pslot_in = '0;
                     prefs_in = '0;
                  end else if (act_ff[slot_ff]) begin
                     pst_in   = ST_OK;
                     prefs_in = refs_ff;
                  end else begin
                     pst_in   = ST_NOTACT;
                     prefs_in = '0;
                  end
               end
               OP_RELEASE: begin
                  if (!found_ff) begin
                     pst_in   = ST_ABSENT;
                     pslot_in = '0;
                     prefs_in = '0;
                  end else if (!act_ff[slot_ff]) begin
                     pst_in   = ST_NOTACT;
                     prefs_in = '0;
                  end else begin
                     nr = (refs_ff != '0) ? refs_ff - REF_W'(1) : '0;
                     if (nr == '0) begin
                        act_in[slot_ff] = 1'b0;
                        push_en = 1'b1;
                     end
                     refs_in  = nr;
                     ram_we   = 1'b1;
                     ram_wd   = {own_ff, rq_ff, nr, esz_ff};
                     pst_in   = ST_OK;
                     prefs_in = nr;
                  end
               end
               OP_CLEAR: begin
                  state_in = S_CLR;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_EVAL: begin
            if (over && cnt_ff != '0) begin
               idx_in   = '0;
               ret_in   = RET_EVAL;
               state_in = S_HD_SCAN;
            end else if (over) begin
               pst_in   = ST_MEM;
               pslot_in = '0;
               prefs_in = '0;
               state_in = S_RESP;
            end else begin
               idx_in   = '0;
               state_in = S_ALLOC;
            end
         end
         S_ALLOC: begin
            if (!val_ff[cur]) begin
               slot_in  = cur;
               state_in = S_FILL;
            end else if (idx_ff == LAST_IDX) begin
               if (cnt_ff != '0) begin
                  idx_in   = '0;
                  ret_in   = RET_FILL;
                  state_in = S_HD_SCAN;
               end else begin
                  pst_in   = ST_FULL;
                  pslot_in = '0;
                  prefs_in = '0;
                  state_in = S_RESP;
               end
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_FILL: begin
            val_in[slot_ff] = 1'b1;
            act_in[slot_ff] = 1'b1;
            ram_we   = 1'b1;
            ram_wd   = {own_ff, rq_ff, REF_W'(1), size_ff};
            used_in  = used_ff + size_ff;
            pst_in   = ST_OK;
            pslot_in = slot_ff;
            prefs_in = REF_W'(1);
            state_in = S_RESP;
         end
         S_CLR: begin
            if (cnt_ff != '0) begin
               idx_in   = '0;
               ret_in   = RET_CLR;
               state_in = S_HD_SCAN;
            end else begin
               pst_in   = ST_OK;
               pslot_in = '0;
               prefs_in = '0;
               state_in = S_RESP;
            end
         end
         S_HD_SCAN: begin
            if (head_vec[cur]) begin
               slot_in  = cur;
               state_in = S_HD_DATA;
            end else if (idx_ff == LAST_IDX) begin
               idx_in = '0;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         S_HD_DATA: begin
            if (out_free) begin
               rv_in       = 1'b1;
               r_status_in = ST_EVICT;
               r_slot_in   = SLOT_W'(slot_ff);
               r_eo_in     = OWNER_W'(32'(rd_own));
               r_er_in     = REQUEST_W'(48'(rd_rq));
               r_refs_in   = '0;
               r_use_in    = used_ev;
               r_last_in   = 1'b0;
               used_in     = used_ev;
               val_in[slot_ff] = 1'b0;
               act_in[slot_ff] = 1'b0;
               remove_en   = 1'b1;
               remove_r    = '0;
               unique case (ret_ff)
                  RET_FILL: state_in = S_FILL;
                  RET_CLR:  state_in = S_CLR;
                  default:  state_in = S_EVAL;
               endcase
            end
         end
         S_RESP: begin
            if (out_free) begin
               rv_in       = 1'b1;
               r_status_in = pst_ff;
               r_slot_in   = SLOT_W'(pslot_ff);
               r_eo_in     = '0;
               r_er_in     = '0;
               r_refs_in   = prefs_ff;
               r_use_in    = used_ff;
               r_last_in   = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // release queue kept as a rank per entry, head has rank zero
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         rank_in[i] = rank_ff[i];
         if (remove_en && val_ff[i] && !act_ff[i] && rank_ff[i] > remove_r) begin
            rank_in[i] = rank_ff[i] - CW'(1);
         end
         if (push_en && slot_ff == IW'(i)) begin
            rank_in[i] = cnt_ff;
         end
      end
      cnt_in = cnt_ff;
      if (remove_en) begin
         cnt_in = cnt_ff - CW'(1);
      end else if (push_en) begin
         cnt_in = cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         val_ff   <= '0;
         act_ff   <= '0;
         cnt_ff   <= '0;
         used_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         val_ff   <= val_in;
         act_ff   <= act_in;
         cnt_ff   <= cnt_in;
         used_ff  <= used_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      own_ff      <= own_in;
      rq_ff       <= rq_in;
      size_ff     <= size_in;
      idx_ff      <= idx_in;
      found_ff    <= found_in;
      slot_ff     <= slot_in;
      refs_ff     <= refs_in;
      esz_ff      <= esz_in;
      ret_ff      <= ret_in;
      pst_ff      <= pst_in;
      pslot_ff    <= pslot_in;
      prefs_ff    <= prefs_in;
      rank_ff     <= rank_in;
      r_status_ff <= r_status_in;
      r_slot_ff   <= r_slot_in;
      r_eo_ff     <= r_eo_in;
      r_er_ff     <= r_er_in;
      r_refs_ff   <= r_refs_in;
      r_use_ff    <= r_use_in;
      r_last_ff   <= r_last_in;
   end

   assign req_if.ready           = (state_ff == S_IDLE) && !reset;
   assign rsp_if.valid           = rv_ff;
   assign rsp_if.status          = r_status_ff;
   assign rsp_if.slot            = r_slot_ff;
   assign rsp_if.evicted_owner   = r_eo_ff;
   assign rsp_if.evicted_request = r_er_ff;
   assign rsp_if.ref_count       = r_refs_ff;
   assign rsp_if.usage_kb        = r_use_ff;
   assign rsp_if.last            = r_last_ff;

   `RLBP_ASSERT(a_act_valid, clock, reset, (act_ff & ~val_ff) == '0)
   `RLBP_ASSERT(a_queue_len, clock, reset, $countones(val_ff & ~act_ff) == 32'(cnt_ff))
   `RLBP_ASSERT_IMP(a_evict_not_last, clock, reset,
      rv_ff && r_status_ff == ST_EVICT, !r_last_ff)
   `RLBP_ASSERT_IMP(a_head_released, clock, reset,
      state_ff == S_HD_DATA, val_ff[slot_ff] && !act_ff[slot_ff])
endmodule

@@ hdl/refcount_lru_buffer_pool_top.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake              payload
// req_if    in   valid/ready            op, owner_id, request_key, item_size_kb
// rsp_if    out  valid/ready            status, slot, evicted_*, ref_count, usage_kb, last
// csr apb   in   psel/penable, pready   paddr, pwdata, prdata
// a key lookup reads then compares each entry walked (up to ENTRIES entries), one ram read port
// each eviction: a head scan of one entry a cycle, a report beat, then back to the budget check, fill or clear
// a store scans for a free slot one entry a cycle; acquire/get/release go from dispatch straight to the response
// reset clears the table at once, no clearing pass
// req ready only between items; a stalled rsp holds the sequencer in place
module refcount_lru_buffer_pool_top #(
   parameter int ENTRIES      = rlbp_pkg::ENTRIES_DEF,
   parameter int OWNER_BITS   = rlbp_pkg::OWNER_BITS_DEF,
   parameter int REQUEST_BITS = rlbp_pkg::REQUEST_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   rlbp_req_if.sink                    req_if,
   rlbp_rsp_if.source                  rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rlbp_pkg::CSR_AW-1:0] paddr,
   input  logic [rlbp_pkg::CSR_DW-1:0] pwdata,
   output logic [rlbp_pkg::CSR_DW-1:0] prdata,
   output logic                        pready
);
   import rlbp_pkg::*;

   logic [SIZE_W-1:0] limit_kb;

   rlbp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .limit_kb (limit_kb)
   );

   rlbp_seq #(
      .ENTRIES      (ENTRIES),
      .OWNER_BITS   (OWNER_BITS),
      .REQUEST_BITS (REQUEST_BITS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .rsp_if   (rsp_if),
      .limit_kb (limit_kb)
   );
endmodule

@@ test/tb_refcount_lru_buffer_pool_top.sv @@
`timescale 1ns / 1ps
module tb_refcount_lru_buffer_pool_top;
   import rlbp_pkg::*;

   localparam int NSLOT = ENTRIES_DEF;
   localparam int QUIET_LIMIT = 20000;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SLOT_W-1:0]    slot;
      logic [OWNER_W-1:0]   ev_owner;
      logic [REQUEST_W-1:0] ev_request;
      logic [REF_W-1:0]     refs;
      logic [SIZE_W-1:0]    usage;
      logic                 last;
   } pool_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [CSR_DW-1:0] pwdata = '0;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   rlbp_req_if req_if ();
   rlbp_rsp_if rsp_if ();

   refcount_lru_buffer_pool_top uut (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // shadow of the pool
   logic [31:0]          limit_kb;
   logic                 e_valid [NSLOT];
   logic                 e_active[NSLOT];
   logic [OWNER_W-1:0]   e_owner [NSLOT];
   logic [REQUEST_W-1:0] e_req   [NSLOT];
   logic [REF_W-1:0]     e_refs  [NSLOT];
   logic [SIZE_W-1:0]    e_size  [NSLOT];
   int                   lru_q[$];
   logic [SIZE_W-1:0]    used_kb;

   pool_rsp_type pending_rsp[$];
   int        errors = 0;
   int        idle_pct = 38;
   int        stall_pct = 38;
   int        quiet = 0;

   initial begin
      req_if.valid = 1'b0;
      req_if.op = '0;
      req_if.owner_id = '0;
      req_if.request_key = '0;
      req_if.item_size_kb = '0;
      rsp_if.ready = 1'b0;
      limit_kb = '0;
      used_kb = '0;
      for (int i = 0; i < NSLOT; i++) begin
         e_valid[i] = 1'b0;
         e_active[i] = 1'b0;
      end
   end

   task automatic push_rsp(logic [STATUS_W-1:0] st, int s, logic [OWNER_W-1:0] eo,
                           logic [REQUEST_W-1:0] er, logic [REF_W-1:0] rc, logic lst);
      pool_rsp_type r;
      r.status = st;
      r.slot = SLOT_W'(s);
      r.ev_owner = eo;
      r.ev_request = er;
      r.refs = rc;
      r.usage = used_kb;
      r.last = lst;
      pending_rsp = {pending_rsp, r};
   endtask

   function automatic int lookup_key(logic [OWNER_W-1:0] o, logic [REQUEST_W-1:0] k);
      for (int i = 0; i < NSLOT; i++)
         if (e_valid[i] && e_owner[i] == o && e_req[i] == k) return i;
      return -1;
   endfunction

   function automatic int first_free();
      for (int i = 0; i < NSLOT; i++)
         if (!e_valid[i]) return i;
      return -1;
   endfunction

   task automatic evict_oldest();
      int s;
      s = lru_q.pop_front();
      used_kb = (used_kb >= e_size[s]) ? used_kb - e_size[s] : '0;
      e_valid[s] = 1'b0;
      e_active[s] = 1'b0;
      push_rsp(ST_EVICT, s, e_owner[s], e_req[s], '0, 1'b0);
   endtask

   task automatic take_ref(int s);
      if (e_active[s]) begin
         if (e_refs[s] != REFS_MAX) e_refs[s]++;
      end else begin
         for (int j = 0; j < lru_q.size(); j++)
            if (lru_q[j] == s) begin
               lru_q.delete(j);
               break;
            end
         e_active[s] = 1'b1;
         e_refs[s] = REF_W'(1);
      end
   endtask

   task automatic predict_pool(logic [OP_W-1:0] op, logic [OWNER_W-1:0] o,
                               logic [REQUEST_W-1:0] k, logic [SIZE_W-1:0] sz);
      int s;
      int f;
      s = lookup_key(o, k);
      case (op)
         OP_STORE: begin
            if (s >= 0) begin
               take_ref(s);
               push_rsp(ST_DUP, s, '0, '0, e_refs[s], 1'b1);
            end else begin
               while ({1'b0, used_kb} + {1'b0, sz} >= {1'b0, limit_kb} && lru_q.size() > 0)
                  evict_oldest();
               if ({1'b0, used_kb} + {1'b0, sz} >= {1'b0, limit_kb}) begin
                  push_rsp(ST_MEM, 0, '0, '0, '0, 1'b1);
               end else begin
                  f = first_free();
                  if (f < 0 && lru_q.size() > 0) begin
                     evict_oldest();
                     f = first_free();
                  end
                  if (f < 0) begin
                     push_rsp(ST_FULL, 0, '0, '0, '0, 1'b1);
                  end else begin
                     e_valid[f] = 1'b1;
                     e_active[f] = 1'b1;
                     e_owner[f] = o;
                     e_req[f] = k;
                     e_refs[f] = REF_W'(1);
                     e_size[f] = sz;
                     used_kb = used_kb + sz;
                     push_rsp(ST_OK, f, '0, '0, REF_W'(1), 1'b1);
                  end
               end
            end
         end
         OP_ACQUIRE: begin
            if (s < 0) begin
               push_rsp(ST_ABSENT, 0, '0, '0, '0, 1'b1);
            end else begin
               take_ref(s);
               push_rsp(ST_OK, s, '0, '0, e_refs[s], 1'b1);
            end
         end
         OP_GET: begin
            if (s < 0) push_rsp(ST_ABSENT, 0, '0, '0, '0, 1'b1);
            else if (e_active[s]) push_rsp(ST_OK, s, '0, '0, e_refs[s], 1'b1);
            else push_rsp(ST_NOTACT, s, '0, '0, '0, 1'b1);
         end
         OP_RELEASE: begin
            if (s < 0) begin
               push_rsp(ST_ABSENT, 0, '0, '0, '0, 1'b1);
            end else if (!e_active[s]) begin
               push_rsp(ST_NOTACT, s, '0, '0, '0, 1'b1);
            end else begin
               if (e_refs[s] != 0) e_refs[s]--;
               if (e_refs[s] == 0) begin
                  e_active[s] = 1'b0;
                  lru_q = {lru_q, s};
               end
               push_rsp(ST_OK, s, '0, '0, e_refs[s], 1'b1);
            end
         end
         OP_CLEAR: begin
            while (lru_q.size() > 0) evict_oldest();
            push_rsp(ST_OK, 0, '0, '0, '0, 1'b1);
         end
         default: ;
      endcase
   endtask

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_beat(logic [OP_W-1:0] op, logic [OWNER_W-1:0] o,
                            logic [REQUEST_W-1:0] k, logic [SIZE_W-1:0] sz);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.op <= op;
      req_if.owner_id <= o;
      req_if.request_key <= k;
      req_if.item_size_kb <= sz;
      forever begin
         @(posedge clock);
         if (req_if.ready) break;
      end
      predict_pool(op, o, k, sz);
      @(negedge clock);
   endtask

   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_limit(logic [31:0] v);
      settle();
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= CSR_AW'(4 * CSR_LIMIT);
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      limit_kb = v;
      @(negedge clock);
   endtask

   // response side
   always @(negedge clock)
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      pool_rsp_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status = rsp_if.status;
         got.slot = rsp_if.slot;
         got.ev_owner = rsp_if.evicted_owner;
         got.ev_request = rsp_if.evicted_request;
         got.refs = rsp_if.ref_count;
         got.usage = rsp_if.usage_kb;
         got.last = rsp_if.last;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected rsp beat: %p", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10) $display("rsp mismatch: exp %p got %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         quiet <= 0;
      else
         quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
         $display("** refcount_lru_buffer_pool_top: FAILED **");
         $finish;
      end
   end

   task automatic test_ref_chain();
      idle_pct = 0;
      stall_pct = 0;
      write_limit(32'hFFFF_FFFF);
      send_beat(OP_STORE, 16'h0001, 32'h0000_0001, 32'd5);
      for (int i = 0; i < 4; i++) send_beat(OP_ACQUIRE, 16'h0001, 32'h0000_0001, '0);
      send_beat(OP_GET, 16'h0001, 32'h0000_0001, '0);
      send_beat(OP_RELEASE, 16'h0001, 32'h0000_0001, '0);
      idle_pct = 38;
      stall_pct = 38;
      settle();
   endtask

   task automatic test_edges();
      write_limit(32'd0);
      send_beat(OP_STORE, 16'hFFFF, 32'hFFFF_FFFF, 32'd0);
      send_beat(OP_ACQUIRE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(OP_GET, 16'h0000, 32'h0000_0000, '0);
      send_beat(OP_RELEASE, 16'hFFFF, 32'h0000_0000, '0);
      send_beat(OP_CLEAR, 16'h0000, 32'h0, '0);
      for (int u = OP_CLEAR + 1; u < 8; u++) send_beat(OP_W'(u), 16'h1234, 32'h5, 32'd7);
      write_limit(32'hFFFF_FFFF);
      send_beat(OP_STORE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
      send_beat(OP_STORE, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF);
      send_beat(OP_STORE, 16'hFFFF, 32'hFFFF_FFFF, 32'd1);
      send_beat(OP_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, '0);
      send_beat(OP_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, '0);
      send_beat(OP_GET, 16'hFFFF, 32'hFFFF_FFFF, '0);
      send_beat(OP_STORE, 16'h0000, 32'h0000_0000, 32'd100);
      send_beat(OP_STORE, 16'hFFFF, 32'hFFFF_FFFF, 32'd3);
      send_beat(OP_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, '0);
      send_beat(OP_CLEAR, 16'h0, 32'h0, '0);
      settle();
   endtask

   task automatic test_table_full();
      write_limit(32'd100000);
      for (int i = 0; i < NSLOT; i++) send_beat(OP_STORE, 16'h0200, 32'(i), 32'd10);
      send_beat(OP_RELEASE, 16'h0200, 32'd3, '0);
      send_beat(OP_RELEASE, 16'h0200, 32'd7, '0);
      send_beat(OP_STORE, 16'h0300, 32'd0, 32'd10);
      send_beat(OP_ACQUIRE, 16'h0200, 32'd7, '0);
      send_beat(OP_STORE, 16'h0300, 32'd1, 32'd10);
      send_beat(OP_STORE, 16'h0300, 32'd0, 32'd10);
      for (int i = 0; i < NSLOT; i++) send_beat(OP_RELEASE, 16'h0200, 32'(i), '0);
      send_beat(OP_RELEASE, 16'h0300, 32'd0, '0);
      send_beat(OP_RELEASE, 16'h0300, 32'd0, '0);
      send_beat(OP_CLEAR, 16'h0, 32'h0, '0);
      settle();
   endtask

   task automatic test_budget();
      write_limit(32'd60);
      for (int i = 0; i < 5; i++) send_beat(OP_STORE, 16'h0400, 32'(i), 32'd10);
      for (int i = 0; i < 4; i++) send_beat(OP_RELEASE, 16'h0400, 32'(i), '0);
      send_beat(OP_STORE, 16'h0401, 32'd0, 32'd25);
      send_beat(OP_STORE, 16'h0401, 32'd1, 32'd55);
      send_beat(OP_RELEASE, 16'h0400, 32'd4, '0);
      send_beat(OP_RELEASE, 16'h0401, 32'd0, '0);
      send_beat(OP_CLEAR, 16'h0, 32'h0, '0);
      settle();
   endtask

   task automatic test_random(int n, logic [31:0] lim, bit hold_mid);
      logic [OP_W-1:0]      op;
      logic [OWNER_W-1:0]   o;
      logic [REQUEST_W-1:0] k;
      logic [SIZE_W-1:0]    sz;
      int                   pick;
      write_limit(lim);
      for (int i = 0; i < n; i++) begin
         if (hold_mid && i == n / 2) settle();
         pick = $urandom_range(99);
         if (pick < 30) op = OP_STORE;
         else if (pick < 45) op = OP_ACQUIRE;
         else if (pick < 58) op = OP_GET;
         else if (pick < 92) op = OP_RELEASE;
         else if (pick < 97) op = OP_CLEAR;
         else op = OP_W'($urandom_range(7, OP_CLEAR + 1));
         if ($urandom_range(9) == 0) begin
            o = OWNER_W'($urandom);
            k = $urandom;
         end else begin
            o = OWNER_W'($urandom_range(3));
            k = $urandom_range(7);
         end
         sz = ($urandom_range(19) == 0) ? $urandom : 32'($urandom_range(40));
         send_beat(op, o, k, sz);
      end
      settle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_ref_chain();
      test_edges();
      test_table_full();
      test_budget();
      test_random(48, 32'd200, 1'b0);
      idle_pct = 0;
      stall_pct = 0;
      test_random(48, 32'hFFFF_FFFF, 1'b1);
      idle_pct = 38;
      stall_pct = 38;
      test_random(48, 32'd1000, 1'b0);
      test_random(48, 32'd1, 1'b0);
      if (errors == 0)
         $display("** refcount_lru_buffer_pool_top: PASSED **");
      else
         $display("** refcount_lru_buffer_pool_top: FAILED **");
      $finish;
   end

endmodule
